FILE: rtl/bbd_pkg.sv
package bbd_pkg;

  // Frame and sample limits.
  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 16384;
  localparam int unsigned SAMPLE_BITS = 16;

  // Widths derived from the limits.
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);       // column index
  localparam int unsigned WID_W  = COL_W + 1;               // width value
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT) + 1;  // height value, input row
  localparam int unsigned OROW_W = ROW_W - 1;               // output row index

  // The line memory holds three raw rows side by side, one lane per row.
  localparam int unsigned NUM_BANKS = 3;
  localparam int unsigned WIN       = 3;
  localparam int unsigned LINE_W    = NUM_BANKS * SAMPLE_BITS;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 2'd3;

  localparam logic [WID_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 15'd1080;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [1:0]             bank_t;

  typedef struct packed {
    logic    op;
    sample_t raw_sample;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        end_of_row;
    logic        end_of_frame;
  } out_beat_t;

  // One column read request travelling from the sequencer to the filter.
  typedef struct packed {
    logic    valid;      // a column is being read this cycle
    logic    is_out;     // the column completes an output pixel
    bank_t   bank_top;
    bank_t   bank_mid;
    bank_t   bank_bot;
    logic    fwd;        // bottom sample is the one being written now
    sample_t fwd_data;
    logic    ix_odd;
    logic    iy_odd;
    logic    eor;
    logic    eof;
  } issue_t;

  function automatic bank_t bank_inc(bank_t b);
    return (b == bank_t'(NUM_BANKS - 1)) ? bank_t'(0) : bank_t'(b + bank_t'(1));
  endfunction

  function automatic bank_t bank_dec(bank_t b);
    return (b == bank_t'(0)) ? bank_t'(NUM_BANKS - 1) : bank_t'(b - bank_t'(1));
  endfunction

endpackage

FILE: rtl/bbd_ram.sv
module bbd_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wmask_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask_i[i]) begin
          mem[waddr_i][i] <= wdata_i[i];
        end
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bbd_ctrl.sv
module bbd_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  input  bbd_pkg::in_beat_t                 in_data_i,
  output logic                              in_stall_o,
  input  logic                              b_hold_i,
  output logic                              ram_we_o,
  output logic [bbd_pkg::LINE_W-1:0]        ram_wmask_o,
  output logic [bbd_pkg::COL_W-1:0]         ram_waddr_o,
  output logic [bbd_pkg::LINE_W-1:0]        ram_wdata_o,
  output logic                              ram_re_o,
  output logic [bbd_pkg::COL_W-1:0]         ram_raddr_o,
  output bbd_pkg::issue_t                   iss_o
);
  import bbd_pkg::*;

  localparam logic [1:0] PRE_DONE = 2'd2;

  logic [WID_W-1:0]  fw_q;
  logic [ROW_W-1:0]  fh_q;
  logic              ox_q, oy_q;
  logic [COL_W-1:0]  in_col_q;
  logic [ROW_W-1:0]  in_row_q;
  bank_t             ib_q;
  logic [COL_W-1:0]  ix_q;
  logic [OROW_W-1:0] iy_q;
  bank_t             iym3_q;
  logic [1:0]        pre_q;

  logic [WID_W-1:0]  w_eff, w_m1_full, x, xp1;
  logic [ROW_W-1:0]  h_eff, h_m1, y, oy1;
  logic [COL_W-1:0]  w_m1, col_r;
  logic              in_frame, past_delay, need_pre, pre_issue, in_acc, step;
  logic              do_write, do_out, last_col, last_row, last;
  bank_t             yb, b_top, b_mid, b_bot;

  always_comb begin
    if (fw_q < WID_W'(2)) begin
      w_eff = WID_W'(2);
    end else if (fw_q > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_q;
    end
    if (fh_q < ROW_W'(2)) begin
      h_eff = ROW_W'(2);
    end else if (fh_q > ROW_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = fh_q;
    end
  end

  assign w_m1_full = w_eff - WID_W'(1);
  assign w_m1      = w_m1_full[COL_W-1:0];
  assign h_m1      = h_eff - ROW_W'(1);

  // Input side: the next item sits at raster position (in_row_q, in_col_q).
  assign in_frame   = in_row_q < h_eff;
  assign oy1        = ROW_W'(oy_q) + ROW_W'(1);
  assign past_delay = (in_row_q > oy1) ||
                      ((in_row_q == oy1) && ({1'b0, in_col_q} >= (WID_W'(ox_q) + WID_W'(1))));

  // Output side: sampling center of the pending output pixel.
  assign x   = {1'b0, ix_q} + WID_W'(ox_q);
  assign xp1 = x + WID_W'(1);
  assign y   = {1'b0, iy_q} + ROW_W'(oy_q);
  assign yb  = oy_q ? bank_inc(iym3_q) : iym3_q;

  assign col_r    = (xp1 >= w_eff) ? w_m1 : xp1[COL_W-1:0];
  assign last_col = ix_q == w_m1;
  assign last_row = iy_q == h_m1[OROW_W-1:0];
  assign last     = last_col && last_row;

  // Rows above and below the center, clamped to the frame, mapped to lanes.
  always_comb begin
    b_top = (y == ROW_W'(0)) ? yb : bank_dec(yb);
    b_mid = (y > h_m1) ? bank_dec(yb) : yb;
    if (y > h_m1) begin
      b_bot = bank_dec(yb);
    end else if (y == h_m1) begin
      b_bot = yb;
    end else begin
      b_bot = bank_inc(yb);
    end
  end

  assign need_pre   = past_delay && (ix_q == '0) && (pre_q != PRE_DONE);
  assign pre_issue  = need_pre && !b_hold_i;
  assign in_stall_o = b_hold_i || need_pre;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign step       = in_acc && !(in_frame && in_data_i.op);
  assign do_write   = step && in_frame;
  assign do_out     = step && past_delay;

  always_comb begin
    for (int k = 0; k < NUM_BANKS; k++) begin
      ram_wmask_o[k*SAMPLE_BITS +: SAMPLE_BITS] = {SAMPLE_BITS{ib_q == bank_t'(k)}};
    end
  end

  assign ram_we_o    = do_write;
  assign ram_waddr_o = in_col_q;
  assign ram_wdata_o = {NUM_BANKS{in_data_i.raw_sample}};
  assign ram_re_o    = !b_hold_i;

  always_comb begin
    if (pre_issue) begin
      ram_raddr_o = (pre_q == 2'd0) ? COL_W'(0) : COL_W'(ox_q);
    end else begin
      ram_raddr_o = col_r;
    end
  end

  always_comb begin
    iss_o.valid    = pre_issue || do_out;
    iss_o.is_out   = do_out;
    iss_o.bank_top = b_top;
    iss_o.bank_mid = b_mid;
    iss_o.bank_bot = b_bot;
    iss_o.fwd      = do_out && (y < h_m1) && (xp1 < w_eff);
    iss_o.fwd_data = in_data_i.raw_sample;
    iss_o.ix_odd   = ix_q[0];
    iss_o.iy_odd   = iy_q[0];
    iss_o.eor      = last_col;
    iss_o.eof      = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= FRAME_WIDTH_RST;
      fh_q     <= FRAME_HEIGHT_RST;
      ox_q     <= 1'b0;
      oy_q     <= 1'b0;
      in_col_q <= '0;
      in_row_q <= '0;
      ib_q     <= '0;
      ix_q     <= '0;
      iy_q     <= '0;
      iym3_q   <= '0;
      pre_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[WID_W-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[ROW_W-1:0];
        CFG_OFFSET_X:     ox_q <= cfg_data_i[0];
        CFG_OFFSET_Y:     oy_q <= cfg_data_i[0];
      endcase
      in_col_q <= '0;
      in_row_q <= '0;
      ib_q     <= '0;
      ix_q     <= '0;
      iy_q     <= '0;
      iym3_q   <= '0;
      pre_q    <= '0;
    end else begin
      if (pre_issue) begin
        pre_q <= pre_q + 2'd1;
      end
      if (step) begin
        if (do_out && last) begin
          in_col_q <= '0;
          in_row_q <= '0;
          ib_q     <= '0;
          ix_q     <= '0;
          iy_q     <= '0;
          iym3_q   <= '0;
          pre_q    <= '0;
        end else begin
          if (in_col_q == w_m1) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + ROW_W'(1);
            ib_q     <= bank_inc(ib_q);
          end else begin
            in_col_q <= in_col_q + COL_W'(1);
          end
          if (do_out) begin
            pre_q <= '0;
            if (last_col) begin
              ix_q   <= '0;
              iy_q   <= iy_q + OROW_W'(1);
              iym3_q <= bank_inc(iym3_q);
            end else begin
              ix_q <= ix_q + COL_W'(1);
            end
          end
        end
      end
    end
  end

endmodule

FILE: rtl/bbd_filt.sv
module bbd_filt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bbd_pkg::issue_t             iss_i,
  input  logic [bbd_pkg::LINE_W-1:0]  ram_rdata_i,
  output logic                        b_hold_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output bbd_pkg::out_beat_t          out_data_o
);
  import bbd_pkg::*;

  issue_t    b_q;
  sample_t   win_q [WIN][WIN];
  logic      c_valid_q, c_ix_odd_q, c_iy_odd_q, c_eor_q, c_eof_q;
  logic      out_valid_q;
  out_beat_t out_data_q;

  logic      out_hold, c_hold;
  sample_t   col_top, col_mid, col_bot;
  logic [SAMPLE_BITS+1:0] orth, diag;
  logic [SAMPLE_BITS:0]   hsum, vsum;
  out_beat_t pix;

  function automatic sample_t lane(logic [LINE_W-1:0] d, bank_t b);
    sample_t s;
    unique case (b)
      2'd0:    s = d[0*SAMPLE_BITS +: SAMPLE_BITS];
      2'd1:    s = d[1*SAMPLE_BITS +: SAMPLE_BITS];
      default: s = d[2*SAMPLE_BITS +: SAMPLE_BITS];
    endcase
    return s;
  endfunction

  assign out_hold = out_valid_q && out_stall_i;
  assign c_hold   = c_valid_q && out_hold;
  assign b_hold_o = b_q.valid && c_hold;

  assign col_top = lane(ram_rdata_i, b_q.bank_top);
  assign col_mid = lane(ram_rdata_i, b_q.bank_mid);
  assign col_bot = b_q.fwd ? b_q.fwd_data : lane(ram_rdata_i, b_q.bank_bot);

  assign orth = (SAMPLE_BITS+2)'(win_q[0][1]) + (SAMPLE_BITS+2)'(win_q[2][1]) +
                (SAMPLE_BITS+2)'(win_q[1][0]) + (SAMPLE_BITS+2)'(win_q[1][2]);
  assign diag = (SAMPLE_BITS+2)'(win_q[0][0]) + (SAMPLE_BITS+2)'(win_q[0][2]) +
                (SAMPLE_BITS+2)'(win_q[2][0]) + (SAMPLE_BITS+2)'(win_q[2][2]);
  assign hsum = (SAMPLE_BITS+1)'(win_q[1][0]) + (SAMPLE_BITS+1)'(win_q[1][2]);
  assign vsum = (SAMPLE_BITS+1)'(win_q[0][1]) + (SAMPLE_BITS+1)'(win_q[2][1]);

  always_comb begin
    pix.end_of_row   = c_eor_q;
    pix.end_of_frame = c_eof_q;
    unique case ({c_iy_odd_q, c_ix_odd_q})
      2'b00: begin
        pix.red   = win_q[1][1];
        pix.green = orth[SAMPLE_BITS+1:2];
        pix.blue  = diag[SAMPLE_BITS+1:2];
      end
      2'b01: begin
        pix.red   = hsum[SAMPLE_BITS:1];
        pix.green = win_q[1][1];
        pix.blue  = vsum[SAMPLE_BITS:1];
      end
      2'b10: begin
        pix.red   = vsum[SAMPLE_BITS:1];
        pix.green = win_q[1][1];
        pix.blue  = hsum[SAMPLE_BITS:1];
      end
      2'b11: begin
        pix.red   = diag[SAMPLE_BITS+1:2];
        pix.green = orth[SAMPLE_BITS+1:2];
        pix.blue  = win_q[1][1];
      end
    endcase
  end

  // Window columns shift left; the newest column enters on the right.
  always_ff @(posedge clk_i) begin
    if (b_q.valid && !c_hold) begin
      for (int r = 0; r < WIN; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= col_top;
      win_q[1][2] <= col_mid;
      win_q[2][2] <= col_bot;
      c_ix_odd_q  <= b_q.ix_odd;
      c_iy_odd_q  <= b_q.iy_odd;
      c_eor_q     <= b_q.eor;
      c_eof_q     <= b_q.eof;
    end
    if (!out_hold && c_valid_q) begin
      out_data_q <= pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q         <= '0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!b_hold_o) begin
        b_q <= iss_i;
      end
      if (!c_hold) begin
        c_valid_q <= b_q.valid && b_q.is_out;
      end
      if (!out_hold) begin
        out_valid_q <= c_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/bilinear_bayer_demosaic_core.sv
// Bilinear RGGB demosaic. Raw samples enter in raster order, one beat per clock, and one
// RGB pixel leaves for every input beat once the sampling window of the first pixel has
// been filled; after the last raw sample of a frame, flush beats (op set) drain the
// remaining pixels, and a flush beat that arrives before the frame is complete is dropped.
// The three most recent raw rows live in one line memory with a single read port, one
// lane per row. Each output pixel reads one new window column from it, so the sustained
// rate is one beat per clock while the output does not stall, except at the start of every
// output row, where the input stalls while the two left columns of the window are read.
// A result passes the issue, window and output registers, and up to three results can
// queue inside the block while the output is stalled. Neighbors outside the frame repeat
// the edge sample. Any configuration write restarts the frame. The line memory needs no
// clearing after reset: every entry is written in the current frame before it is read.
module bilinear_bayer_demosaic_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bbd_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bbd_pkg::out_beat_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bbd_pkg::*;

  // Sequencer to memory and filter.
  logic              ram_we, ram_re, b_hold;
  logic [LINE_W-1:0] ram_wmask, ram_wdata, ram_rdata;
  logic [COL_W-1:0]  ram_waddr, ram_raddr;
  issue_t            iss;

  // Counters, configuration, column read scheduling and the input handshake.
  bbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .b_hold_i    (b_hold),
    .ram_we_o    (ram_we),
    .ram_wmask_o (ram_wmask),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .iss_o       (iss)
  );

  // Line memory: one entry per column, one lane per buffered row.
  bbd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .wmask_i (ram_wmask),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Column assembly, 3x3 window, interpolation and the output register.
  bbd_filt u_filt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_i       (iss),
    .ram_rdata_i (ram_rdata),
    .b_hold_o    (b_hold),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // The bottom sample is only bypassed when it is being written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) iss.fwd |-> ram_we)
    else $error("bypassed sample without a line memory write");

  // A column request must always come with a memory read.
  assert property (@(posedge clk_i) disable iff (!rst_ni) iss.valid |-> ram_re)
    else $error("column request while the memory read is held");

  // The last pixel of a frame is also the last pixel of its row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.end_of_frame) |-> out_data_o.end_of_row)
    else $error("end of frame without end of row");
`endif

endmodule
